// ----- design/wsp_pkg.sv -----
// Shared types, codes and constants of the WAV stream parser.
// The PCM8 lookup table is built here at elaboration. No dependencies.
package wsp_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_HDR0    = 4'd0,
    PH_FORM    = 4'd1,
    PH_FMTHDR  = 4'd2,
    PH_FMT     = 4'd3,
    PH_SKIPFMT = 4'd4,
    PH_HDR     = 4'd5,
    PH_SKIP    = 4'd6,
    PH_DATA    = 4'd7,
    PH_DONE    = 4'd8,
    PH_ERR     = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    F_PCM8  = 3'd0,
    F_PCM16 = 3'd1,
    F_PCM24 = 3'd2,
    F_PCM32 = 3'd3,
    F_FLT32 = 3'd4,
    F_FLT64 = 3'd5
  } fmt_t;

  localparam logic [15:0] ERR_BAD_FIRST_ID = 16'd1;
  localparam logic [15:0] ERR_NO_FMT       = 16'd2;
  localparam logic [15:0] ERR_SHORT_FMT    = 16'd3;
  localparam logic [15:0] ERR_UNSUPPORTED  = 16'd4;
  localparam logic [15:0] ERR_EOF_HEADER   = 16'd5;
  localparam logic [15:0] ERR_EOF_DATA     = 16'd6;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [15:0] AF_PCM   = 16'd1;
  localparam logic [15:0] AF_FLOAT = 16'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // Scale mantissas (with hidden bit) and biased base exponents.
  localparam logic [23:0] PCM8_K     = 24'h80_8081;
  localparam logic [23:0] PCM16_CM   = 24'h80_0100;
  localparam logic [23:0] PCM24_CM   = 24'h80_0001;
  localparam logic [23:0] PCM32_CM   = 24'h80_0000;
  localparam logic [7:0]  PCM16_BASE = 8'd112;
  localparam logic [7:0]  PCM24_BASE = 8'd104;
  localparam logic [7:0]  PCM32_BASE = 8'd96;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] raw;
    fmt_t        fmt;
    logic [15:0] channel;
    logic [15:0] detail;
    logic        last;
  } item_t;

  typedef logic [31:0] lut_t [256];

  // Rounds s * mag * 2^e to single precision, nearest even, normal range only.
  function automatic logic [31:0] round_pack(logic s, logic [63:0] mag, int e);
    int          msb;
    int          sh;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] r;
    msb = 0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) msb = i;
    end
    if (msb > 23) begin
      sh   = msb - 23;
      keep = mag >> sh;
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      if (keep[24]) begin
        keep = keep >> 1;
        sh   = sh + 1;
      end
    end else begin
      keep = mag << (23 - msb);
      sh   = msb - 23;
    end
    r = {s, 8'(e + sh + 23 + 127), keep[22:0]};
    if (mag == 64'd0) r = {s, 31'd0};
    return r;
  endfunction

  function automatic lut_t build_pcm8_lut();
    lut_t        t;
    logic [31:0] p;
    logic [63:0] pm;
    logic [63:0] one;
    int          ep;
    one = 64'd1 << 40;
    for (int u = 0; u < 256; u++) begin
      p = round_pack(1'b0, 64'(PCM8_K) * 64'(u), -30);
      if (u == 0) begin
        t[u] = 32'hBF80_0000;
      end else begin
        ep = int'(p[30:23]) - 127;
        pm = {40'd0, 1'b1, p[22:0]} << (ep + 17);
        if (pm >= one) t[u] = round_pack(1'b0, pm - one, -40);
        else t[u] = round_pack(1'b1, one - pm, -40);
      end
    end
    return t;
  endfunction

  localparam lut_t PCM8_LUT = build_pcm8_lut();

endpackage

// ----- design/wav_stream_parser_to_float.sv -----
// Top level of the WAV stream parser: parser, item queue and float converter.
// Depends on wsp_pkg, wsp_front, wsp_queue and wsp_back.
//
// The input channel takes one byte of a RIFF/WAVE file per beat, with
// end_of_file set on the final byte. The output channel gives one result per
// beat: a format item when the data chunk header completes, a float sample
// with its channel index for each whole sample, or an error item.
// One input beat is taken per cycle while in_stall is low. A result is written
// into the queue at the edge that accepts the beat that completes it, then
// passes the normalise, multiply and round stages of the converter, each one
// registered. While the receiver does not stall, the converter sustains one
// result per cycle with its single 24 by 24 bit multiplier stage.
// When the receiver stalls, the converter holds its output and stops; the
// four-entry queue then fills, and in_stall rises once it is full.
// Reset clears the parser to expect the first chunk header and empties the
// queue and converter. After an error or the end of the data chunk, bytes are
// taken and ignored until the next reset.
module wav_stream_parser_to_float import wsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   byte_in,
  input  logic         end_of_file,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   kind,
  output logic [31:0]  value,
  output logic [15:0]  channel,
  output logic [15:0]  detail,
  output logic         last_sample
);

  logic   fire;
  logic   q_push, q_pop, q_valid, q_full;
  item_t  f_item, q_item;
  phase_t phase;

  assign in_stall = q_full;
  assign fire     = in_valid && !in_stall;

  wsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .byte_in     (byte_in),
    .end_of_file (end_of_file),
    .push        (q_push),
    .item        (f_item),
    .phase       (phase)
  );

  wsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (f_item),
    .pop     (q_pop),
    .valid   (q_valid),
    .full    (q_full),
    .rd_item (q_item)
  );

  wsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .value       (value),
    .channel     (channel),
    .detail      (detail),
    .last_sample (last_sample)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("item queue written while full");

  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE || phase == PH_ERR) |-> !q_push)
    else $error("item produced after the stream ended");

  a_last_is_sample: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_sample) |-> (kind == KIND_SAMPLE))
    else $error("last_sample set on a non-sample beat");
`endif

endmodule

// ----- design/wsp_front.sv -----
// Front end: walks the RIFF/WAVE byte stream and classifies each beat.
// Emits format, error and raw sample items. Depends on wsp_pkg.
module wsp_front import wsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  byte_in,
  input  logic        end_of_file,
  output logic        push,
  output item_t       item,
  output phase_t      phase
);

  phase_t      phase_next;
  logic [3:0]  cnt, cnt_next;
  logic [31:0] id_shift, id_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [15:0] audio_format, audio_format_next;
  logic [15:0] num_channels, num_channels_next;
  logic [31:0] frame_rate, frame_rate_next;
  logic [15:0] bits_per_sample, bits_per_sample_next;
  logic [63:0] sample_assembly, sample_assembly_next;
  logic [15:0] channel_index, channel_index_next;

  logic        has;
  item_t       res;
  logic [3:0]  bps;
  logic [3:0]  cnt_inc;
  logic [15:0] ch_inc;
  logic        is_last;

  function automatic logic [31:0] padded(logic [31:0] n);
    return (n == 32'hFFFF_FFFF) ? n : n + {31'd0, n[0]};
  endfunction

  function automatic logic supported(logic [15:0] af, logic [15:0] bits);
    logic ok;
    ok = 1'b0;
    if (af == AF_PCM) ok = (bits == 16'd8) || (bits == 16'd16) ||
                           (bits == 16'd24) || (bits == 16'd32);
    else if (af == AF_FLOAT) ok = (bits == 16'd32) || (bits == 16'd64);
    return ok;
  endfunction

  function automatic fmt_t fmt_of(logic [15:0] af, logic [15:0] bits);
    fmt_t f;
    if (af == AF_FLOAT) f = (bits == 16'd64) ? F_FLT64 : F_FLT32;
    else begin
      case (bits[6:3])
        4'd1:    f = F_PCM8;
        4'd2:    f = F_PCM16;
        4'd3:    f = F_PCM24;
        default: f = F_PCM32;
      endcase
    end
    return f;
  endfunction

  always_comb begin
    phase_next           = phase;
    cnt_next             = cnt;
    id_shift_next        = id_shift;
    chunk_length_next    = chunk_length;
    audio_format_next    = audio_format;
    num_channels_next    = num_channels;
    frame_rate_next      = frame_rate;
    bits_per_sample_next = bits_per_sample;
    sample_assembly_next = sample_assembly;
    channel_index_next   = channel_index;
    has                  = 1'b0;
    res                  = '0;
    res.kind             = KIND_ERROR;
    res.fmt              = F_PCM8;
    bps                  = bits_per_sample[6:3];
    cnt_inc              = cnt + 4'd1;
    ch_inc               = channel_index + 16'd1;
    is_last              = 1'b0;
    if (phase != PH_DONE && phase != PH_ERR) begin
      unique case (phase)
        PH_HDR0, PH_FMTHDR, PH_HDR: begin
          if (cnt < 4'd4) begin
            id_shift_next = {byte_in, id_shift[31:8]};
            if (cnt == 4'd0) chunk_length_next = '0;
          end else begin
            chunk_length_next[{cnt[1:0], 3'b000} +: 8] =
              chunk_length[{cnt[1:0], 3'b000} +: 8] | byte_in;
          end
          cnt_next = cnt_inc;
          if (cnt == 4'd7) begin
            cnt_next = '0;
            if (phase == PH_HDR0) begin
              if (id_shift_next != ID_RIFF && id_shift_next != ID_WAVE) begin
                has = 1'b1; res.detail = ERR_BAD_FIRST_ID; phase_next = PH_ERR;
              end else begin
                phase_next = PH_FORM;
              end
            end else if (phase == PH_FMTHDR) begin
              if (id_shift_next != ID_FMT) begin
                has = 1'b1; res.detail = ERR_NO_FMT; phase_next = PH_ERR;
              end else if (chunk_length_next < 32'd16) begin
                has = 1'b1; res.detail = ERR_SHORT_FMT; phase_next = PH_ERR;
              end else begin
                chunk_length_next = padded(chunk_length_next - 32'd16);
                phase_next = PH_FMT;
              end
            end else if (id_shift_next == ID_DATA) begin
              if (!supported(audio_format, bits_per_sample)) begin
                has = 1'b1; res.detail = ERR_UNSUPPORTED; phase_next = PH_ERR;
              end else begin
                has         = 1'b1;
                res.kind    = KIND_FORMAT;
                res.raw     = {32'd0, frame_rate};
                res.channel = num_channels;
                res.detail  = bits_per_sample;
                sample_assembly_next = '0;
                channel_index_next   = '0;
                phase_next = (chunk_length_next < {19'd0, bits_per_sample[15:3]}) ?
                             PH_DONE : PH_DATA;
              end
            end else begin
              chunk_length_next = padded(chunk_length_next);
              phase_next = (chunk_length_next == 32'd0) ? PH_HDR : PH_SKIP;
            end
          end
        end
        PH_FORM: begin
          cnt_next = cnt_inc;
          if (cnt == 4'd3) begin
            cnt_next   = '0;
            phase_next = PH_FMTHDR;
          end
        end
        PH_FMT: begin
          if (cnt == 4'd0) begin
            audio_format_next    = {8'd0, byte_in};
            num_channels_next    = '0;
            frame_rate_next      = '0;
            bits_per_sample_next = '0;
          end else if (cnt < 4'd2) begin
            audio_format_next[{cnt[0], 3'b000} +: 8] = byte_in;
          end else if (cnt < 4'd4) begin
            num_channels_next[{cnt[0], 3'b000} +: 8] = byte_in;
          end else if (cnt < 4'd8) begin
            frame_rate_next[{cnt[1:0], 3'b000} +: 8] = byte_in;
          end else if (cnt >= 4'd14) begin
            bits_per_sample_next[{cnt[0], 3'b000} +: 8] = byte_in;
          end
          cnt_next = cnt_inc;
          if (cnt == 4'd15) begin
            cnt_next   = '0;
            phase_next = (chunk_length == 32'd0) ? PH_HDR : PH_SKIPFMT;
          end
        end
        PH_SKIPFMT, PH_SKIP: begin
          chunk_length_next = chunk_length - 32'd1;
          if (chunk_length_next == 32'd0) phase_next = PH_HDR;
        end
        PH_DATA: begin
          sample_assembly_next[{cnt[2:0], 3'b000} +: 8] =
            sample_assembly[{cnt[2:0], 3'b000} +: 8] | byte_in;
          chunk_length_next = chunk_length - 32'd1;
          cnt_next          = cnt_inc;
          if (cnt_inc >= bps) begin
            is_last     = chunk_length_next < {28'd0, bps};
            has         = 1'b1;
            res.kind    = KIND_SAMPLE;
            res.raw     = sample_assembly_next;
            res.fmt     = fmt_of(audio_format, bits_per_sample);
            res.channel = channel_index;
            res.last    = is_last;
            cnt_next             = '0;
            sample_assembly_next = '0;
            channel_index_next   = ch_inc;
            if (num_channels != 16'd0 && ch_inc >= num_channels) channel_index_next = '0;
            if (is_last) phase_next = PH_DONE;
          end
        end
        default: phase_next = PH_ERR;
      endcase
      if (end_of_file && phase_next != PH_DONE && phase_next != PH_ERR) begin
        has        = 1'b1;
        res        = '0;
        res.kind   = KIND_ERROR;
        res.fmt    = F_PCM8;
        res.detail = (phase_next == PH_DATA) ? ERR_EOF_DATA : ERR_EOF_HEADER;
        phase_next = PH_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
      cnt   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      id_shift        <= id_shift_next;
      chunk_length    <= chunk_length_next;
      audio_format    <= audio_format_next;
      num_channels    <= num_channels_next;
      frame_rate      <= frame_rate_next;
      bits_per_sample <= bits_per_sample_next;
      sample_assembly <= sample_assembly_next;
      channel_index   <= channel_index_next;
    end
  end

  assign push = fire && has;
  assign item = res;

endmodule

// ----- design/wsp_queue.sv -----
// Short item queue between the parser and the converter.
// Depends on wsp_pkg for the item type and depth.
module wsp_queue import wsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output logic  valid,
  output logic  full,
  output item_t rd_item
);

  item_t                 entries [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QPTR_W:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + (QPTR_W + 1)'(1);
      else if (pop && !push) count <= count - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_item;
  end

  assign valid   = count != '0;
  assign full    = count == (QPTR_W + 1)'(QDEPTH);
  assign rd_item = entries[rd_ptr];

endmodule

// ----- design/wsp_back.sv -----
// Back end: three-stage conversion of queued items to single-precision results.
// PCM16/24/32 is normalised, scaled by a constant, rounded. Depends on wsp_pkg.
module wsp_back import wsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  item_t        q_item,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   kind,
  output logic [31:0]  value,
  output logic [15:0]  channel,
  output logic [15:0]  detail,
  output logic         last_sample
);

  typedef struct packed {
    kind_t       kind;
    logic [15:0] channel;
    logic [15:0] detail;
    logic        last;
    logic        bypass;
    logic [31:0] direct;
    logic        sign;
    logic        zero;
    logic [7:0]  eb;
  } side_t;

  logic        adv;
  logic        s1_valid, s2_valid;
  side_t       s1_side, s2_side, s1_side_next;
  logic [23:0] s1_mant, s1_cm, s1_mant_next, s1_cm_next;
  logic [47:0] s2_prod;

  logic [31:0] iv, mag, norm;
  logic [4:0]  msb;
  logic [5:0]  ev;
  logic        rup;
  logic [24:0] mant25;
  logic [7:0]  base;

  logic [7:0]  e3;
  logic [22:0] f3;
  logic        g3, st3, up3;
  logic [30:0] bits3;
  logic [31:0] val3;

  function automatic logic [31:0] f64_to_f32(logic [63:0] b);
    logic        s;
    logic [10:0] ex;
    logic [51:0] fr;
    logic [52:0] m, kp, lowmask, rm, half;
    logic [5:0]  sh;
    logic        up;
    logic [31:0] r;
    s  = b[63];
    ex = b[62:52];
    fr = b[51:0];
    m  = {ex != 11'd0, fr};
    sh = 6'(11'd926 - ex);
    kp = m >> sh;
    lowmask = (53'd1 << sh) - 53'd1;
    rm   = m & lowmask;
    half = 53'd1 << (sh - 6'd1);
    if (ex == 11'h7FF) begin
      r = (fr != 52'd0) ? {s, 8'hFF, 1'b1, fr[50:29]} : {s, 8'hFF, 23'd0};
    end else if (ex > 11'd1150) begin
      r = {s, 8'hFF, 23'd0};
    end else if (ex >= 11'd897) begin
      up = fr[28] & ((|fr[27:0]) | fr[29]);
      r  = {s, 8'(ex - 11'd896), fr[51:29]} + {31'd0, up};
    end else if (ex >= 11'd873) begin
      up = (rm > half) || (rm == half && kp[0]);
      r  = {s, 8'd0, kp[22:0]} + {31'd0, up};
    end else begin
      r = {s, 31'd0};
    end
    return r;
  endfunction

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_valid;

  always_comb begin
    case (q_item.fmt)
      F_PCM16: iv = {{16{q_item.raw[15]}}, q_item.raw[15:0]};
      F_PCM24: iv = {{8{q_item.raw[23]}}, q_item.raw[23:0]};
      default: iv = q_item.raw[31:0];
    endcase
    mag = iv[31] ? (32'd0 - iv) : iv;
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    norm   = mag << (5'd31 - msb);
    rup    = norm[7] & ((|norm[6:0]) | norm[8]);
    mant25 = {1'b0, norm[31:8]} + {24'd0, rup};
    if (mant25[24]) begin
      s1_mant_next = 24'h80_0000;
      ev           = {1'b0, msb} + 6'd1;
    end else begin
      s1_mant_next = mant25[23:0];
      ev           = {1'b0, msb};
    end
    case (q_item.fmt)
      F_PCM16: begin s1_cm_next = PCM16_CM; base = PCM16_BASE; end
      F_PCM24: begin s1_cm_next = PCM24_CM; base = PCM24_BASE; end
      default: begin s1_cm_next = PCM32_CM; base = PCM32_BASE; end
    endcase
    s1_side_next.kind    = q_item.kind;
    s1_side_next.channel = q_item.channel;
    s1_side_next.detail  = q_item.detail;
    s1_side_next.last    = q_item.last;
    s1_side_next.sign    = iv[31];
    s1_side_next.zero    = mag == 32'd0;
    s1_side_next.eb      = base + {2'd0, ev};
    s1_side_next.bypass  = 1'b1;
    s1_side_next.direct  = q_item.raw[31:0];
    if (q_item.kind == KIND_SAMPLE) begin
      case (q_item.fmt)
        F_PCM8:  s1_side_next.direct = PCM8_LUT[q_item.raw[7:0]];
        F_FLT64: s1_side_next.direct = f64_to_f32(q_item.raw);
        F_PCM16, F_PCM24, F_PCM32: s1_side_next.bypass = 1'b0;
        default: s1_side_next.direct = q_item.raw[31:0];
      endcase
    end
  end

  always_comb begin
    if (s2_prod[47]) begin
      e3  = s2_side.eb + 8'd1;
      f3  = s2_prod[46:24];
      g3  = s2_prod[23];
      st3 = |s2_prod[22:0];
    end else begin
      e3  = s2_side.eb;
      f3  = s2_prod[45:23];
      g3  = s2_prod[22];
      st3 = |s2_prod[21:0];
    end
    up3   = g3 & (st3 | f3[0]);
    bits3 = {e3, f3} + {30'd0, up3};
    if (s2_side.bypass) val3 = s2_side.direct;
    else if (s2_side.zero) val3 = 32'd0;
    else val3 = {s2_side.sign, bits3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side     <= s1_side_next;
      s1_mant     <= s1_mant_next;
      s1_cm       <= s1_cm_next;
      s2_side     <= s1_side;
      s2_prod     <= s1_mant * s1_cm;
      kind        <= s2_side.kind;
      value       <= val3;
      channel     <= s2_side.channel;
      detail      <= s2_side.detail;
      last_sample <= s2_side.last;
    end
  end

endmodule
